// ===== sv/rtc_pkg.sv =====
// Shared types and constants for the real-time counter block.
// Holds the request kinds, the register map and the beat structs.
// No dependencies.
package rtc_pkg;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	localparam logic [4:0] SEL_TASK_START  = 5'd0;
	localparam logic [4:0] SEL_TASK_STOP   = 5'd1;
	localparam logic [4:0] SEL_TASK_CLEAR  = 5'd2;
	localparam logic [4:0] SEL_TASK_TRIGOV = 5'd3;
	localparam logic [4:0] SEL_EVENT0      = 5'd4;
	localparam logic [4:0] SEL_INTENSET    = 5'd10;
	localparam logic [4:0] SEL_INTENCLR    = 5'd11;
	localparam logic [4:0] SEL_EVTEN       = 5'd12;
	localparam logic [4:0] SEL_EVTENSET    = 5'd13;
	localparam logic [4:0] SEL_EVTENCLR    = 5'd14;
	localparam logic [4:0] SEL_COUNTER     = 5'd15;
	localparam logic [4:0] SEL_PRESCALER   = 5'd16;
	localparam logic [4:0] SEL_CC0         = 5'd17;
	localparam logic [4:0] SEL_POWER       = 5'd21;

	// Slots the register map offers for event flags and compare registers.
	localparam int EV_SLOTS = 6;
	localparam int CC_SLOTS = 4;

	localparam int EV_TICK  = 0;
	localparam int EV_OVF   = 1;
	localparam int EV_CMP0  = 2;
	localparam int IEN_CMP0 = 16;

	typedef struct packed {
		logic [31:0] wdata;
		logic [4:0]  reg_sel;
		req_t        req_type;
	} item_t;

	typedef struct packed {
		logic        access_error;
		logic        irq;
		logic [31:0] rdata;
	} result_t;

endpackage

// ===== sv/rtc_core.sv =====
// State and register logic of the real-time counter: count, prescaler,
// compare registers, event flags and enables. Updates once per item.
// Depends on rtc_pkg.
module rtc_core #(
	parameter int COUNT_BITS    = 24,
	parameter int PRESCALE_BITS = 12,
	parameter int NUM_COMPARE   = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_fire,
	input  rtc_pkg::item_t   item,
	output rtc_pkg::result_t result
);
	import rtc_pkg::*;

	localparam int EVF_W  = NUM_COMPARE + 2;
	localparam int EV_MAP = (EVF_W < EV_SLOTS) ? EVF_W : EV_SLOTS;
	localparam int CC_MAP = (NUM_COMPARE < CC_SLOTS) ? NUM_COMPARE : CC_SLOTS;

	logic [COUNT_BITS-1:0]    count_q, count_n;
	logic [PRESCALE_BITS-1:0] phase_q, phase_n;
	logic [PRESCALE_BITS-1:0] pval_q, pval_n;
	logic [COUNT_BITS-1:0]    cmp_q [NUM_COMPARE];
	logic [COUNT_BITS-1:0]    cmp_n [NUM_COMPARE];
	logic [EVF_W-1:0]         flags_q, flags_n;
	logic [31:0]              inten_q, inten_n;
	logic [31:0]              evten_q, evten_n;
	logic                     run_q, run_n;
	logic                     pwr_q, pwr_n;

	logic [31:0]           rdata;
	logic                  err;
	logic                  hit;
	logic                  irq;
	logic [COUNT_BITS-1:0] count_inc;

	assign count_inc = count_q + COUNT_BITS'(1);

	always_comb begin
		count_n = count_q;
		phase_n = phase_q;
		pval_n  = pval_q;
		cmp_n   = cmp_q;
		flags_n = flags_q;
		inten_n = inten_q;
		evten_n = evten_q;
		run_n   = run_q;
		pwr_n   = pwr_q;
		rdata   = '0;
		err     = 1'b0;
		hit     = 1'b0;
		case (item.req_type)
			REQ_READ: begin
				if (!pwr_q || item.reg_sel <= SEL_TASK_TRIGOV) begin
					err = 1'b1;
				end else begin
					for (int i = 0; i < EV_MAP; i++) begin
						if (item.reg_sel == SEL_EVENT0 + 5'(i)) begin
							rdata = 32'(flags_q[i]);
							hit   = 1'b1;
						end
					end
					for (int i = 0; i < CC_MAP; i++) begin
						if (item.reg_sel == SEL_CC0 + 5'(i)) begin
							rdata = 32'(cmp_q[i]);
							hit   = 1'b1;
						end
					end
					case (item.reg_sel)
						SEL_INTENSET, SEL_INTENCLR: rdata = inten_q;
						SEL_EVTEN, SEL_EVTENSET, SEL_EVTENCLR: rdata = evten_q;
						SEL_COUNTER:   rdata = 32'(count_q);
						SEL_PRESCALER: rdata = 32'(pval_q);
						SEL_POWER:     rdata = 32'(pwr_q);
						default:       err = !hit;
					endcase
				end
			end
			REQ_WRITE: begin
				if (!pwr_q && item.reg_sel != SEL_POWER) begin
					err = 1'b1;
				end else begin
					for (int i = 0; i < EV_MAP; i++) begin
						if (item.reg_sel == SEL_EVENT0 + 5'(i)) begin
							flags_n[i] = item.wdata[0];
							hit        = 1'b1;
						end
					end
					for (int i = 0; i < CC_MAP; i++) begin
						if (item.reg_sel == SEL_CC0 + 5'(i)) begin
							cmp_n[i]            = item.wdata[COUNT_BITS-1:0];
							flags_n[EV_CMP0 + i] = 1'b0;
							hit                 = 1'b1;
						end
					end
					case (item.reg_sel)
						SEL_TASK_START: begin
							if (item.wdata == 32'd1) begin
								run_n   = 1'b1;
								phase_n = '0;
							end
						end
						SEL_TASK_STOP: begin
							if (item.wdata == 32'd1) run_n = 1'b0;
						end
						SEL_TASK_CLEAR: begin
							if (item.wdata == 32'd1) begin
								count_n = '0;
								flags_n = '0;
								phase_n = '0;
							end
						end
						SEL_TASK_TRIGOV: begin
							if (item.wdata == 32'd1) count_n = {{(COUNT_BITS-1){1'b1}}, 1'b0};
						end
						SEL_INTENSET: inten_n = inten_q | item.wdata;
						SEL_INTENCLR: inten_n = inten_q & ~item.wdata;
						SEL_EVTENSET: evten_n = evten_q | item.wdata;
						SEL_EVTENCLR: evten_n = evten_q & ~item.wdata;
						SEL_PRESCALER: begin
							if (run_q) err = 1'b1;
							else       pval_n = item.wdata[PRESCALE_BITS-1:0];
						end
						SEL_POWER: begin
							pwr_n = item.wdata[0];
							if (!item.wdata[0]) begin
								run_n   = 1'b0;
								count_n = '0;
								phase_n = '0;
							end
						end
						// Read-only registers and unmapped selectors land here.
						default: err = !hit;
					endcase
				end
			end
			REQ_TICK: begin
				if (pwr_q && run_q) begin
					if (phase_q >= pval_q) begin
						phase_n           = '0;
						count_n           = count_inc;
						flags_n[EV_TICK]  = 1'b1;
						if (count_inc == '0) flags_n[EV_OVF] = 1'b1;
						for (int i = 0; i < NUM_COMPARE; i++) begin
							if (count_inc == cmp_q[i]) flags_n[EV_CMP0 + i] = 1'b1;
						end
					end else begin
						phase_n = phase_q + PRESCALE_BITS'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		irq = (flags_n[EV_TICK] & inten_n[0]) | (flags_n[EV_OVF] & inten_n[1]);
		for (int i = 0; i < NUM_COMPARE; i++) begin
			irq = irq | (flags_n[EV_CMP0 + i] & inten_n[IEN_CMP0 + i]);
		end
	end

	assign result.rdata        = rdata;
	assign result.irq          = irq;
	assign result.access_error = err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
			pval_q  <= '0;
			for (int i = 0; i < NUM_COMPARE; i++) cmp_q[i] <= '0;
			flags_q <= '0;
			inten_q <= '0;
			evten_q <= '0;
			run_q   <= 1'b0;
			pwr_q   <= 1'b0;
		end else if (item_fire) begin
			count_q <= count_n;
			phase_q <= phase_n;
			pval_q  <= pval_n;
			cmp_q   <= cmp_n;
			flags_q <= flags_n;
			inten_q <= inten_n;
			evten_q <= evten_n;
			run_q   <= run_n;
			pwr_q   <= pwr_n;
		end
	end

endmodule

// ===== sv/rtc_counter_with_compare_events.sv =====
// Top level of the real-time counter: input register, counter core and
// result register. Depends on rtc_pkg and rtc_core.
//
// Usage: each input beat is a register read, a register write or one tick of
// the low-frequency clock. The request kind and register selector travel in
// s_axis_tuser, the write data in s_axis_tdata. Every input beat yields
// exactly one result beat carrying the read data, the interrupt line after
// the item and an access error flag.
// An accepted beat waits in the input register; when it advances, the counter
// state updates and the result is registered together.
// Throughput is one beat per cycle while results are taken; the only loop
// is the state update in rtc_core. The input side stays ready while a result
// waits, as long as the input register is empty; when m_axis_tready stays
// low, one beat waits in the input register and s_axis_tready then drops.
// After reset the block is powered off and stopped, with count, prescaler,
// compare registers, flags and enables all zero and no beat pending.
module rtc_counter_with_compare_events #(
	parameter int COUNT_BITS    = 24,
	parameter int PRESCALE_BITS = 12,
	parameter int NUM_COMPARE   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] wdata
	input  logic [6:0]  s_axis_tuser,  // [1:0] req_type, [6:2] reg_sel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] rdata
	output logic [1:0]  m_axis_tuser   // [0] irq, [1] access_error
);
	import rtc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t core_res;
	logic    advance;

	// The item in the input register moves on whenever the result slot is free.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.req_type <= req_t'(s_axis_tuser[1:0]);
			item_s1.reg_sel  <= s_axis_tuser[6:2];
			item_s1.wdata    <= s_axis_tdata;
		end
	end

	rtc_core #(
		.COUNT_BITS   (COUNT_BITS),
		.PRESCALE_BITS(PRESCALE_BITS),
		.NUM_COMPARE  (NUM_COMPARE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_fire(advance),
		.item     (item_s1),
		.result   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= core_res;
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_q.rdata;
	assign m_axis_tuser[0] = out_q.irq;
	assign m_axis_tuser[1] = out_q.access_error;

endmodule
